// ===== hdl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// shared constants and control types for the order book matcher
// ----------------------------------------------------------------------------
package lobm_pkg;

   localparam int BOOK_DEPTH_DEF  = 64;
   localparam int PRICE_BITS_DEF  = 32;
   localparam int AMOUNT_BITS_DEF = 32;
   localparam int BACKLOG_BITS    = 48;

   // book operation broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_POP    = 2'd1,
      OP_DEC    = 2'd2,
      OP_INSERT = 2'd3
   } book_op_type;

   typedef struct packed {
      book_op_type op;
   } book_ctl_type;

   typedef struct packed {
      logic head_valid;
      logic full;
   } book_status_type;

endpackage

// ===== hdl/lobm_if.sv =====
// ----------------------------------------------------------------------------
// lobm_req_if / lobm_rsp_if
// order and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface lobm_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] order_price;
   logic [31:0] order_amount;
   modport source (output valid, cmd, order_price, order_amount, input ready);
   modport sink   (input valid, cmd, order_price, order_amount, output ready);
endinterface

interface lobm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] filled_amount;
   logic [31:0] rested_amount;
   logic [31:0] dropped_amount;
   logic        book_full;
   logic [47:0] backlog_total;
   modport source (output valid, filled_amount, rested_amount, dropped_amount,
                   book_full, backlog_total, input ready);
   modport sink   (input valid, filled_amount, rested_amount, dropped_amount,
                   book_full, backlog_total, output ready);
endinterface

// ===== hdl/lobm_cell.sv =====
// ----------------------------------------------------------------------------
// lobm_cell
// one book slot: price, amount and valid, shifting with its neighbours
// ----------------------------------------------------------------------------
module lobm_cell #(
   parameter int   PW         = 32,
   parameter int   AW         = 32,
   parameter logic DESCENDING = 1'b1,
   parameter logic HEAD       = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lobm_pkg::book_ctl_type ctl,
   input  logic [PW-1:0]         ins_price,
   input  logic [AW-1:0]         ins_amount,
   input  logic [AW-1:0]         dec_amount,
   input  logic                  left_valid,
   input  logic                  left_behind,
   input  logic [PW-1:0]         left_price,
   input  logic [AW-1:0]         left_amount,
   input  logic                  right_valid,
   input  logic [PW-1:0]         right_price,
   input  logic [AW-1:0]         right_amount,
   output logic                  valid,
   output logic                  behind,
   output logic [PW-1:0]         price,
   output logic [AW-1:0]         amount
);
   import lobm_pkg::*;

   logic          valid_ff, valid_in;
   logic [PW-1:0] price_ff, price_in;
   logic [AW-1:0] amount_ff, amount_in;

   // slot lies at or after the insertion point
   assign behind = !valid_ff ||
                   (DESCENDING ? (price_ff < ins_price) : (price_ff > ins_price));

   always_comb begin
      valid_in  = valid_ff;
      price_in  = price_ff;
      amount_in = amount_ff;
      case (ctl.op)
         OP_POP: begin
            valid_in  = right_valid;
            price_in  = right_price;
            amount_in = right_amount;
         end
         OP_DEC: begin
            if (HEAD) amount_in = dec_amount;
         end
         OP_INSERT: begin
            if (behind) begin
               if (left_behind) begin
                  valid_in  = left_valid;
                  price_in  = left_price;
                  amount_in = left_amount;
               end else begin
                  valid_in  = 1'b1;
                  price_in  = ins_price;
                  amount_in = ins_amount;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      price_ff  <= price_in;
      amount_ff <= amount_in;
   end

   assign valid  = valid_ff;
   assign price  = price_ff;
   assign amount = amount_ff;
endmodule

// ===== hdl/lobm_book.sv =====
// ----------------------------------------------------------------------------
// lobm_book
// price-ordered book as a row of cells, best entry in cell zero
// ----------------------------------------------------------------------------
module lobm_book #(
   parameter int   DEPTH      = 64,
   parameter int   PW         = 32,
   parameter int   AW         = 32,
   parameter logic DESCENDING = 1'b1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lobm_pkg::book_ctl_type    ctl,
   input  logic [PW-1:0]            ins_price,
   input  logic [AW-1:0]            ins_amount,
   input  logic [AW-1:0]            dec_amount,
   output lobm_pkg::book_status_type status,
   output logic [PW-1:0]            head_price,
   output logic [AW-1:0]            head_amount
);
   import lobm_pkg::*;

   logic [DEPTH-1:0]         v;
   logic [DEPTH-1:0]         b;
   logic [DEPTH-1:0][PW-1:0] p;
   logic [DEPTH-1:0][AW-1:0] a;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic          lv, lb, rv;
      logic [PW-1:0] lp, rp;
      logic [AW-1:0] la, ra;
      if (i == 0) begin : g_first
         assign lv = 1'b0; assign lb = 1'b0; assign lp = '0; assign la = '0;
      end else begin : g_mid
         assign lv = v[i-1]; assign lb = b[i-1]; assign lp = p[i-1]; assign la = a[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign rv = 1'b0; assign rp = '0; assign ra = '0;
      end else begin : g_nxt
         assign rv = v[i+1]; assign rp = p[i+1]; assign ra = a[i+1];
      end
      lobm_cell #(
         .PW(PW), .AW(AW), .DESCENDING(DESCENDING), .HEAD(i == 0)
      ) u_cell (
         .clock, .reset, .ctl, .ins_price, .ins_amount, .dec_amount,
         .left_valid(lv), .left_behind(lb), .left_price(lp), .left_amount(la),
         .right_valid(rv), .right_price(rp), .right_amount(ra),
         .valid(v[i]), .behind(b[i]), .price(p[i]), .amount(a[i])
      );
   end

   assign status.head_valid = v[0];
   assign status.full       = v[DEPTH-1];
   assign head_price        = p[0];
   assign head_amount       = a[0];
endmodule

// ===== hdl/limit_order_book_matcher_core.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// limit order matcher with a buy book and a sell book held in cell rows
// ----------------------------------------------------------------------------
// sequence: each order runs through idle, match (one crossed book entry consumed per step), rest
//    and done; a new order is accepted only in idle, after the last result has been loaded,
//    and an order stays in done while a finished result waits on rsp ready
// reset: synchronous, empties both books and clears the backlog total
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core #(
   parameter int BOOK_DEPTH  = lobm_pkg::BOOK_DEPTH_DEF,
   parameter int PRICE_BITS  = lobm_pkg::PRICE_BITS_DEF,
   parameter int AMOUNT_BITS = lobm_pkg::AMOUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   lobm_req_if.sink    req_ch,
   lobm_rsp_if.source  rsp_ch
);
   import lobm_pkg::*;

   localparam int PW = PRICE_BITS;
   localparam int AW = AMOUNT_BITS;
   localparam int BW = BACKLOG_BITS;

   // one-hot sequencer
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_REST  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic          side_ff, side_in;        // 1 for a sell order
   logic [PW-1:0] price_ff, price_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] filled_ff, filled_in;
   logic [AW-1:0] rested_ff, rested_in;
   logic [AW-1:0] dropped_ff, dropped_in;
   logic          full_ff, full_in;
   logic [BW-1:0] backlog_ff, backlog_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   o_fill_ff, o_rest_ff, o_drop_ff;
   logic          o_full_ff;
   logic [BW-1:0] o_back_ff;

   // book ports
   book_ctl_type    buy_ctl, sell_ctl;
   book_status_type buy_st, sell_st;
   logic [PW-1:0]   buy_hp, sell_hp;
   logic [AW-1:0]   buy_ha, sell_ha;
   logic [AW-1:0]   dec_amt;

   // order fields fitted to the configured widths
   logic [63:0]   price_ext, amount_ext;
   logic [63:0]   fill_ext, rest_ext, drop_ext;

   // opposite book head, chosen by side
   logic          opp_valid, own_full, crosses, take_all;
   logic [PW-1:0] opp_price;
   logic [AW-1:0] opp_amount, take;
   logic [BW:0]   back_sum;
   logic          req_xfer, rsp_load;

   assign req_xfer   = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign price_ext  = 64'(req_ch.order_price);
   assign amount_ext = 64'(req_ch.order_amount);

   assign opp_valid  = side_ff ? buy_st.head_valid : sell_st.head_valid;
   assign opp_price  = side_ff ? buy_hp : sell_hp;
   assign opp_amount = side_ff ? buy_ha : sell_ha;
   assign own_full   = side_ff ? sell_st.full : buy_st.full;
   assign crosses    = side_ff ? (opp_price >= price_ff) : (opp_price <= price_ff);
   assign take_all   = (opp_amount <= rem_ff);
   assign take       = take_all ? opp_amount : rem_ff;
   assign dec_amt    = opp_amount - rem_ff;
   assign back_sum   = {1'b0, backlog_ff} + (BW+1)'(rem_ff);

   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in   = state_ff;
      side_in    = side_ff;
      price_in   = price_ff;
      rem_in     = rem_ff;
      filled_in  = filled_ff;
      rested_in  = rested_ff;
      dropped_in = dropped_ff;
      full_in    = full_ff;
      backlog_in = backlog_ff;
      buy_ctl.op  = OP_HOLD;
      sell_ctl.op = OP_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               side_in    = req_ch.cmd;
               price_in   = price_ext[PW-1:0];
               rem_in     = amount_ext[AW-1:0];
               filled_in  = '0;
               rested_in  = '0;
               dropped_in = '0;
               full_in    = 1'b0;
               state_in   = S_MATCH;
            end
         end
         S_MATCH: begin
            // one opposite head consumed per cycle
            if (rem_ff == '0 || !opp_valid || !crosses) begin
               state_in = S_REST;
            end else begin
               rem_in     = rem_ff - take;
               filled_in  = filled_ff + take;
               backlog_in = backlog_ff - BW'(take);
               if (side_ff) buy_ctl.op  = take_all ? OP_POP : OP_DEC;
               else         sell_ctl.op = take_all ? OP_POP : OP_DEC;
            end
         end
         S_REST: begin
            if (rem_ff != '0) begin
               if (own_full) begin
                  dropped_in = rem_ff;
                  full_in    = 1'b1;
               end else begin
                  rested_in  = rem_ff;
                  backlog_in = back_sum[BW] ? {BW{1'b1}} : back_sum[BW-1:0];
                  if (side_ff) sell_ctl.op = OP_INSERT;
                  else         buy_ctl.op  = OP_INSERT;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)                         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   assign fill_ext = 64'(filled_ff);
   assign rest_ext = 64'(rested_ff);
   assign drop_ext = 64'(dropped_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         backlog_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         backlog_ff   <= backlog_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      side_ff    <= side_in;
      price_ff   <= price_in;
      rem_ff     <= rem_in;
      filled_ff  <= filled_in;
      rested_ff  <= rested_in;
      dropped_ff <= dropped_in;
      full_ff    <= full_in;
      if (rsp_load) begin
         o_fill_ff <= fill_ext[31:0];
         o_rest_ff <= rest_ext[31:0];
         o_drop_ff <= drop_ext[31:0];
         o_full_ff <= full_ff;
         o_back_ff <= backlog_ff;
      end
   end

   // buy book best-first is highest price, sell book lowest price
   lobm_book #(.DEPTH(BOOK_DEPTH), .PW(PW), .AW(AW), .DESCENDING(1'b1)) u_buy (
      .clock, .reset, .ctl(buy_ctl), .ins_price(price_ff), .ins_amount(rem_ff),
      .dec_amount(dec_amt), .status(buy_st), .head_price(buy_hp), .head_amount(buy_ha)
   );

   lobm_book #(.DEPTH(BOOK_DEPTH), .PW(PW), .AW(AW), .DESCENDING(1'b0)) u_sell (
      .clock, .reset, .ctl(sell_ctl), .ins_price(price_ff), .ins_amount(rem_ff),
      .dec_amount(dec_amt), .status(sell_st), .head_price(sell_hp), .head_amount(sell_ha)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.filled_amount  = o_fill_ff;
   assign rsp_ch.rested_amount  = o_rest_ff;
   assign rsp_ch.dropped_amount = o_drop_ff;
   assign rsp_ch.book_full      = o_full_ff;
   assign rsp_ch.backlog_total  = o_back_ff;

   // sequencer stays one-hot
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("sequencer state not one-hot");

   // remaining amount never grows while matching
   a_rem_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MATCH) |=> (rem_ff <= $past(rem_ff)))
      else $error("remaining amount grew during match");

   // a new result only appears out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside done state");
endmodule

// ===== tb/limit_order_book_matcher_core_tb.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core_tb
// random and directed orders against a behavioural copy of both books, with
// every result compared field by field in arrival order
// ----------------------------------------------------------------------------
typedef struct packed {
   logic [31:0] filled;
   logic [31:0] rested;
   logic [31:0] dropped;
   logic        full;
   logic [47:0] backlog;
} fill_report_type;

class book_scoreboard;
   localparam int DEPTH = 64;
   logic [31:0] bid_px[DEPTH], bid_qty[DEPTH], ask_px[DEPTH], ask_qty[DEPTH];
   int bid_n, ask_n;
   fill_report_type pending[$];
   int errors;

   function new();
      bid_n = 0;
      ask_n = 0;
      errors = 0;
   endfunction

   // match one order and queue the report it should produce
   function void note_order(logic side, logic [31:0] px, logic [31:0] qty);
      logic [31:0] rem, take;
      logic [63:0] acc;
      fill_report_type r;
      int pos;
      rem = qty;
      r = '0;
      if (!side) begin
         while (rem != 0 && ask_n > 0 && ask_px[0] <= px) begin
            take = (ask_qty[0] < rem) ? ask_qty[0] : rem;
            ask_qty[0] -= take;
            rem -= take;
            r.filled += take;
            if (ask_qty[0] == 0) begin
               for (int i = 1; i < ask_n; i++) begin
                  ask_px[i-1] = ask_px[i];
                  ask_qty[i-1] = ask_qty[i];
               end
               ask_n--;
            end
         end
      end else begin
         while (rem != 0 && bid_n > 0 && bid_px[0] >= px) begin
            take = (bid_qty[0] < rem) ? bid_qty[0] : rem;
            bid_qty[0] -= take;
            rem -= take;
            r.filled += take;
            if (bid_qty[0] == 0) begin
               for (int i = 1; i < bid_n; i++) begin
                  bid_px[i-1] = bid_px[i];
                  bid_qty[i-1] = bid_qty[i];
               end
               bid_n--;
            end
         end
      end
      if (rem != 0) begin
         if ((side ? ask_n : bid_n) >= DEPTH) begin
            r.dropped = rem;
            r.full = 1'b1;
         end else if (!side) begin
            pos = 0;
            while (pos < bid_n && !(bid_px[pos] < px)) pos++;
            for (int i = bid_n; i > pos; i--) begin
               bid_px[i] = bid_px[i-1];
               bid_qty[i] = bid_qty[i-1];
            end
            bid_px[pos] = px;
            bid_qty[pos] = rem;
            bid_n++;
            r.rested = rem;
         end else begin
            pos = 0;
            while (pos < ask_n && !(ask_px[pos] > px)) pos++;
            for (int i = ask_n; i > pos; i--) begin
               ask_px[i] = ask_px[i-1];
               ask_qty[i] = ask_qty[i-1];
            end
            ask_px[pos] = px;
            ask_qty[pos] = rem;
            ask_n++;
            r.rested = rem;
         end
      end
      acc = 0;
      for (int i = 0; i < bid_n; i++) acc += bid_qty[i];
      for (int i = 0; i < ask_n; i++) acc += ask_qty[i];
      r.backlog = (acc > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : acc[47:0];
      pending.push_back(r);
   endfunction

   function void check_report(fill_report_type got);
      fill_report_type exp;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t unexpected result %h", $time, got);
         return;
      end
      exp = pending.pop_front();
      if (got.filled !== exp.filled) begin
         errors++;
         $display("%0t filled exp %h got %h", $time, exp.filled, got.filled);
      end
      if (got.rested !== exp.rested) begin
         errors++;
         $display("%0t rested exp %h got %h", $time, exp.rested, got.rested);
      end
      if (got.dropped !== exp.dropped) begin
         errors++;
         $display("%0t dropped exp %h got %h", $time, exp.dropped, got.dropped);
      end
      if (got.full !== exp.full) begin
         errors++;
         $display("%0t book_full exp %b got %b", $time, exp.full, got.full);
      end
      if (got.backlog !== exp.backlog) begin
         errors++;
         $display("%0t backlog exp %h got %h", $time, exp.backlog, got.backlog);
      end
   endfunction
endclass

module limit_order_book_matcher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   lobm_req_if req_ch ();
   lobm_rsp_if rsp_ch ();

   limit_order_book_matcher_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #2 clock = ~clock;

   book_scoreboard sb = new();
   int send_idle_pct = 36;   // chance per cycle that the sender holds back
   int recv_idle_pct = 58;   // chance per cycle that the receiver holds back
   int hold_off = 0;         // long receiver stall, cycles left
   int cycles = 0;
   logic base_side = 1'b0;
   logic [31:0] mid_px = 32'd1000;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = 1'b0;
      req_ch.order_price = '0;
      req_ch.order_amount = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver: random ready plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checks on each transfer
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_report({rsp_ch.filled_amount, rsp_ch.rested_amount,
                          rsp_ch.dropped_amount, rsp_ch.book_full,
                          rsp_ch.backlog_total});
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL limit_order_book_matcher_core");
         $finish;
      end
   end

   // offer one order and wait for its transfer; the prediction is made here
   // valid stays high into the next order unless the sender idles
   task automatic send_order(logic side, logic [31:0] px, logic [31:0] qty);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= side;
      req_ch.order_price <= px;
      req_ch.order_amount <= qty;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_order(side, px, qty);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // mostly small amounts near a drifting mid price, some full-range values
   task automatic random_order();
      logic side;
      logic [31:0] px, qty;
      int k;
      k = $urandom_range(99);
      side = (k < 70) ? ($urandom_range(99) < 60 ? base_side : ~base_side)
                      : 1'($urandom_range(1));
      if (k < 85) px = mid_px + $urandom_range(20) - 10;
      else px = $urandom;
      k = $urandom_range(99);
      if (k < 75) qty = $urandom_range(50, 1);
      else if (k < 80) qty = 0;
      else qty = $urandom;
      send_order(side, px, qty);
      if ($urandom_range(99) < 3) base_side = ~base_side;
      if ($urandom_range(99) < 2) mid_px = $urandom_range(2000, 20);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, crossing, equal-price time priority, zero amount
      send_order(1'b0, 32'd0, 32'd0);
      send_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(1'b0, 32'hFFFF_FFFF, 32'd5);
      send_order(1'b0, 32'd0, 32'hFFFF_FFFF);
      send_order(1'b1, 32'd0, 32'hFFFF_FFFF);
      send_order(1'b0, 32'd100, 32'd7);
      send_order(1'b0, 32'd100, 32'd3);
      send_order(1'b1, 32'd100, 32'd8);
      send_order(1'b1, 32'd90, 32'd10);
      send_order(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
      send_order(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
      send_order(1'b1, 32'd50, 32'd0);
      send_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(1'b1, 32'd0, 32'hFFFF_FFFF);
      drain();

      // pause for a full drain, then send a run of small buy orders at prices 10 to 14
      for (int i = 0; i < 70; i++) send_order(1'b0, 32'd10 + (i % 5), 32'd2);
      // one sell order at price 0 for the full amount
      send_order(1'b1, 32'd0, 32'hFFFF_FFFF);
      drain();

      // long receiver hold-off while orders keep coming
      hold_off = 300;
      for (int i = 0; i < 40; i++) random_order();
      drain();

      for (int i = 0; i < 530; i++) random_order();
      drain();
      send_idle_pct = 58;
      recv_idle_pct = 36;
      for (int i = 0; i < 530; i++) random_order();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 530; i++) random_order();
      drain();
      repeat (200) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS limit_order_book_matcher_core");
      else
         $display("FAIL limit_order_book_matcher_core");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/lobm_pkg.sv
hdl/lobm_if.sv
hdl/lobm_cell.sv
hdl/lobm_book.sv
hdl/limit_order_book_matcher_core.sv
tb/limit_order_book_matcher_core_tb.sv
